// ===== rtl/esn_pkg.sv =====
// shared types, codes and the tanh table for the echo state network step
// no dependencies

package esn_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned LEAK_W   = 13;
  localparam int unsigned OIDX_W   = 2;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned PROD_W   = 34;
  localparam int unsigned TANH_N   = 1024;
  localparam int unsigned TANH_AW  = 10;
  localparam logic [LEAK_W-1:0] LEAK_ONE   = 13'd4096;
  localparam logic [LEAK_W-1:0] LEAK_RESET = 13'd1229;
  localparam logic [63:0] EXP_STEP = 64'd1040706261;

  typedef enum logic [CMD_W-1:0] {
    CMD_IN_W   = 3'd0,
    CMD_REC_W  = 3'd1,
    CMD_RO_W   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SAMPLE = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_IN, S_REC, S_DRN, S_ACT, S_LUT, S_LK1, S_LK2, S_DRN2, S_WR,
    S_RO, S_DRN3, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_IN, K_REC, K_RO, K_LK1, K_LK2
  } kind_t;

  typedef logic signed [VAL_W-1:0] tanh_rom_t [TANH_N];

  function automatic tanh_rom_t build_tanh();
    tanh_rom_t r;
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] n;
    logic [63:0] d2;
    logic [VAL_W-1:0] mag;
    int m;
    int b;
    u = 64'd1 << 30;
    for (m = 0; m <= 512; m++) begin
      num = (64'd1 << 30) - u;
      den = (64'd1 << 30) + u;
      n   = (num << 13) + den;
      d2  = den << 1;
      mag = '0;
      for (b = 13; b >= 0; b--) begin
        if (n >= (d2 << b)) begin
          n = n - (d2 << b);
          mag[b] = 1'b1;
        end
      end
      if (512 + m < TANH_N) r[512 + m] = mag;
      if (m > 0) r[512 - m] = -mag;
      u = (u * EXP_STEP + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

endpackage

// ===== rtl/esn_if.sv =====
// item channels and configuration channel of the echo state network step
// depends on esn_pkg

interface esn_in_if;
  logic                          valid;
  logic                          ready;
  logic [esn_pkg::CMD_W-1:0]     command;
  logic [esn_pkg::IDX_W-1:0]     row;
  logic [esn_pkg::IDX_W-1:0]     col;
  logic signed [esn_pkg::VAL_W-1:0] value;
  logic                          last;
  modport source (output valid, command, row, col, value, last, input ready);
  modport sink (input valid, command, row, col, value, last, output ready);
endinterface

interface esn_out_if;
  logic                          valid;
  logic                          ready;
  logic [esn_pkg::OIDX_W-1:0]    out_index;
  logic signed [esn_pkg::VAL_W-1:0] out_value;
  logic                          out_last;
  modport source (output valid, out_index, out_value, out_last, input ready);
  modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface

interface esn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [esn_pkg::LEAK_W-1:0]    leak_factor;
  modport source (output valid, leak_factor, input ready);
  modport sink (input valid, leak_factor, output ready);
endinterface

// ===== rtl/esn_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies

module esn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/echo_state_reservoir_step_top.sv =====
// Leaky echo state network step in Q4.12. Weight, clear and sample items are
// taken only while idle. A sample with last set runs an update on one shared
// 17x17 multiply-accumulate: every neuron sums NUM_INPUTS + NUM_NEURONS
// products, then drains, looks up tanh and adds two leak products; then each
// of the NUM_OUTPUTS readouts sums NUM_NEURONS products and waits for its
// result to be taken. No input item and no leak write is taken during an
// update. Neuron state is double buffered in two rams.
// depends on esn_pkg, esn_if and esn_ram

module echo_state_reservoir_step_top #(
  parameter int unsigned NUM_NEURONS = 64,
  parameter int unsigned NUM_INPUTS  = 8,
  parameter int unsigned NUM_OUTPUTS = 4
) (
  input logic       clk,
  input logic       rst,
  esn_in_if.sink    items,
  esn_out_if.source results,
  esn_cfg_if.sink   cfg
);
  import esn_pkg::*;

  localparam int unsigned R_AW   = NUM_NEURONS > 1 ? $clog2(NUM_NEURONS) : 1;
  localparam int unsigned I_AW   = NUM_INPUTS > 1 ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned O_AW   = NUM_OUTPUTS > 1 ? $clog2(NUM_OUTPUTS) : 1;
  localparam int unsigned MAXN   = NUM_NEURONS > NUM_INPUTS ? NUM_NEURONS : NUM_INPUTS;
  localparam int unsigned J_W    = MAXN > 1 ? $clog2(MAXN) : 1;
  localparam int unsigned WIN_D  = NUM_NEURONS * NUM_INPUTS;
  localparam int unsigned WREC_D = NUM_NEURONS * NUM_NEURONS;
  localparam int unsigned WRO_D  = NUM_OUTPUTS * NUM_NEURONS;
  localparam int unsigned WIN_AW  = WIN_D > 1 ? $clog2(WIN_D) : 1;
  localparam int unsigned WREC_AW = WREC_D > 1 ? $clog2(WREC_D) : 1;
  localparam int unsigned WRO_AW  = WRO_D > 1 ? $clog2(WRO_D) : 1;
  localparam logic signed [ACC_W-1:0] SPAN = ACC_W'(64'd1 << 27);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2048);
  localparam tanh_rom_t TANH_ROM = build_tanh();

  state_t state, state_next;

  logic [LEAK_W-1:0] leak;
  logic [LEAK_W-1:0] alpha;

  logic [R_AW-1:0] i;
  logic [J_W-1:0]  j;
  logic [O_AW-1:0] o;
  logic [WIN_AW-1:0]  ain;
  logic [WREC_AW-1:0] arec;
  logic [WRO_AW-1:0]  aro;
  logic cur;
  logic [NUM_NEURONS-1:0] vld0, vld1;
  logic [NUM_INPUTS-1:0]  svld;

  logic issue;
  kind_t issue_k;
  logic j_clr, j_last, acc_clr, acc_ld, start, i_step, o_step, wr_n, out_ld;

  logic p0_v, p0_sv, p0_nv, p0_bank;
  kind_t p0_k;
  logic p1_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [TANH_AW-1:0] tidx;
  logic signed [VAL_W-1:0] tval, prev_val;
  logic prev_ok;

  logic signed [VAL_W-1:0] win_q, wrec_q, wro_q, samp_q, b0_q, b1_q, nval, rval;
  logic accept;
  logic [11:0] win_wa, wrec_wa, wro_wa;
  logic row_r, col_i, col_r, row_o;
  logic bank_re, bank_sel;
  logic [R_AW-1:0] bank_ra;
  logic signed [16:0] ma, mb;
  logic signed [VAL_W-1:0] bq;
  logic signed [ACC_W-1:0] sh;

  assign accept   = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign alpha = (leak > LEAK_ONE) ? LEAK_ONE : leak;

  assign row_r = {1'b0, items.row} < 7'(NUM_NEURONS);
  assign row_o = {1'b0, items.row} < 7'(NUM_OUTPUTS);
  assign col_i = {1'b0, items.col} < 7'(NUM_INPUTS);
  assign col_r = {1'b0, items.col} < 7'(NUM_NEURONS);
  assign win_wa  = 12'(items.row) * 12'(NUM_INPUTS) + 12'(items.col);
  assign wrec_wa = 12'(items.row) * 12'(NUM_NEURONS) + 12'(items.col);
  assign wro_wa  = 12'(items.row) * 12'(NUM_NEURONS) + 12'(items.col);

  // weight and sample stores
  esn_ram #(.WIDTH(VAL_W), .DEPTH(WIN_D)) u_win (
    .clk, .we(accept && items.command == CMD_IN_W && row_r && col_i),
    .waddr(win_wa[WIN_AW-1:0]), .wdata(items.value),
    .re(issue && issue_k == K_IN), .raddr(ain), .rdata(win_q));

  esn_ram #(.WIDTH(VAL_W), .DEPTH(WREC_D)) u_wrec (
    .clk, .we(accept && items.command == CMD_REC_W && row_r && col_r),
    .waddr(wrec_wa[WREC_AW-1:0]), .wdata(items.value),
    .re(issue && issue_k == K_REC), .raddr(arec), .rdata(wrec_q));

  esn_ram #(.WIDTH(VAL_W), .DEPTH(WRO_D)) u_wro (
    .clk, .we(accept && items.command == CMD_RO_W && row_o && col_r),
    .waddr(wro_wa[WRO_AW-1:0]), .wdata(items.value),
    .re(issue && issue_k == K_RO), .raddr(aro), .rdata(wro_q));

  esn_ram #(.WIDTH(VAL_W), .DEPTH(NUM_INPUTS)) u_samp (
    .clk, .we(accept && items.command == CMD_SAMPLE && col_i),
    .waddr(items.col[I_AW-1:0]), .wdata(items.value),
    .re(issue && issue_k == K_IN), .raddr(j[I_AW-1:0]), .rdata(samp_q));

  // neuron state banks, cur holds the last finished state
  assign bank_ra  = (state == S_ACT) ? i : j[R_AW-1:0];
  assign bank_sel = (state == S_RO) ? ~cur : cur;
  assign bank_re  = (state == S_ACT) || (issue && (issue_k == K_REC || issue_k == K_RO));

  esn_ram #(.WIDTH(VAL_W), .DEPTH(NUM_NEURONS)) u_bank0 (
    .clk, .we(wr_n && cur), .waddr(i), .wdata(nval),
    .re(bank_re && !bank_sel), .raddr(bank_ra), .rdata(b0_q));

  esn_ram #(.WIDTH(VAL_W), .DEPTH(NUM_NEURONS)) u_bank1 (
    .clk, .we(wr_n && !cur), .waddr(i), .wdata(nval),
    .re(bank_re && bank_sel), .raddr(bank_ra), .rdata(b1_q));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue   = 1'b0;
    issue_k = K_IN;
    j_clr   = 1'b0;
    acc_clr = 1'b0;
    acc_ld  = 1'b0;
    start   = 1'b0;
    i_step  = 1'b0;
    o_step  = 1'b0;
    wr_n    = 1'b0;
    out_ld  = 1'b0;
    j_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && items.command == CMD_SAMPLE && items.last) begin
          start = 1'b1;
          state_next = S_IN;
        end
      end
      S_IN: begin
        issue = 1'b1;
        issue_k = K_IN;
        j_last = (j == J_W'(NUM_INPUTS - 1));
        if (j_last) begin
          j_clr = 1'b1;
          state_next = S_REC;
        end
      end
      S_REC: begin
        issue = 1'b1;
        issue_k = K_REC;
        j_last = (j == J_W'(NUM_NEURONS - 1));
        if (j_last) begin
          j_clr = 1'b1;
          state_next = S_DRN;
        end
      end
      S_DRN: begin
        if (!p0_v && !p1_v) state_next = S_ACT;
      end
      S_ACT: begin
        acc_ld = 1'b1;
        state_next = S_LUT;
      end
      S_LUT: state_next = S_LK1;
      S_LK1: begin
        issue = 1'b1;
        issue_k = K_LK1;
        state_next = S_LK2;
      end
      S_LK2: begin
        issue = 1'b1;
        issue_k = K_LK2;
        state_next = S_DRN2;
      end
      S_DRN2: begin
        if (!p0_v && !p1_v) state_next = S_WR;
      end
      S_WR: begin
        wr_n = 1'b1;
        i_step = 1'b1;
        acc_clr = 1'b1;
        state_next = (i == R_AW'(NUM_NEURONS - 1)) ? S_RO : S_IN;
      end
      S_RO: begin
        issue = 1'b1;
        issue_k = K_RO;
        j_last = (j == J_W'(NUM_NEURONS - 1));
        if (j_last) begin
          j_clr = 1'b1;
          state_next = S_DRN3;
        end
      end
      S_DRN3: begin
        if (!p0_v && !p1_v) begin
          out_ld = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (results.ready) begin
          acc_clr = 1'b1;
          o_step = 1'b1;
          state_next = (o == O_AW'(NUM_OUTPUTS - 1)) ? S_IDLE : S_RO;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // counters, valid bits and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      leak <= LEAK_RESET;
      cur  <= 1'b0;
      vld0 <= '0;
      vld1 <= '0;
      svld <= '0;
      i <= '0;
      j <= '0;
      o <= '0;
      ain <= '0;
      arec <= '0;
      aro <= '0;
    end else begin
      if (cfg.valid && cfg.ready) leak <= cfg.leak_factor;
      if (accept && items.command == CMD_CLEAR) begin
        vld0 <= '0;
        vld1 <= '0;
      end
      if (accept && items.command == CMD_SAMPLE && col_i) svld[items.col[I_AW-1:0]] <= 1'b1;
      if (start) begin
        i <= '0;
        j <= '0;
        o <= '0;
        ain <= '0;
        arec <= '0;
        aro <= '0;
      end
      if (issue && issue_k != K_LK1 && issue_k != K_LK2) begin
        j <= j_clr ? '0 : j + 1'b1;
        unique case (issue_k)
          K_IN:    ain  <= ain + 1'b1;
          K_REC:   arec <= arec + 1'b1;
          default: aro  <= aro + 1'b1;
        endcase
      end
      if (wr_n) begin
        if (cur) vld0[i] <= 1'b1;
        else vld1[i] <= 1'b1;
      end
      if (i_step) i <= (i == R_AW'(NUM_NEURONS - 1)) ? '0 : i + 1'b1;
      if (o_step) begin
        o <= o + 1'b1;
        if (o == O_AW'(NUM_OUTPUTS - 1)) cur <= ~cur;
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_v <= 1'b0;
      p1_v <= 1'b0;
    end else begin
      p0_v <= issue;
      p1_v <= p0_v;
    end
  end

  always_ff @(posedge clk) begin
    p0_k    <= issue_k;
    p0_sv   <= svld[j[I_AW-1:0]];
    p0_bank <= bank_sel;
    p0_nv   <= bank_sel ? vld1[j[R_AW-1:0]] : vld0[j[R_AW-1:0]];
    if (state == S_ACT) prev_ok <= cur ? vld1[i] : vld0[i];
  end

  assign bq = p0_bank ? b1_q : b0_q;

  always_comb begin
    unique case (p0_k)
      K_IN: begin
        ma = {win_q[VAL_W-1], win_q};
        mb = p0_sv ? {samp_q[VAL_W-1], samp_q} : '0;
      end
      K_REC: begin
        ma = {wrec_q[VAL_W-1], wrec_q};
        mb = p0_nv ? {bq[VAL_W-1], bq} : '0;
      end
      K_RO: begin
        ma = {wro_q[VAL_W-1], wro_q};
        mb = p0_nv ? {bq[VAL_W-1], bq} : '0;
      end
      K_LK1: begin
        ma = {4'b0000, LEAK_ONE - alpha};
        mb = {prev_val[VAL_W-1], prev_val};
      end
      default: begin
        ma = {4'b0000, alpha};
        mb = {tval[VAL_W-1], tval};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (p1_v) acc <= acc + ACC_W'(prod);
    else if (start || acc_clr) acc <= '0;
    else if (acc_ld) acc <= HALF;
    if (state == S_ACT) begin
      if (acc < -SPAN) tidx <= '0;
      else if (acc >= SPAN) tidx <= '1;
      else tidx <= TANH_AW'((acc + SPAN) >>> 18);
    end
    if (state == S_LUT) begin
      tval <= TANH_ROM[tidx];
      prev_val <= prev_ok ? (cur ? b1_q : b0_q) : '0;
    end
  end

  // rounding, saturation and result register
  always_comb begin
    sh = (state == S_WR) ? (acc >>> 12) : ((acc + HALF) >>> 12);
    if (sh > ACC_W'(32767)) nval = 16'sh7fff;
    else if (sh < -ACC_W'(32768)) nval = 16'sh8000;
    else nval = VAL_W'(sh);
    rval = nval;
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      results.out_value <= rval;
      results.out_index <= OIDX_W'(o);
      results.out_last  <= (o == O_AW'(NUM_OUTPUTS - 1));
    end
  end

  assign results.valid = (state == S_OUT);

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("input taken while a result waits");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    p1_v |-> $past(p0_v))
    else $error("product stage without issue");
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR || state == S_ACT || state == S_OUT) |-> (!p0_v && !p1_v))
    else $error("accumulator used before pipeline drained");
  a_end: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.out_last) |=> items.ready)
    else $error("block not idle after final result");

endmodule

// ===== test/esn_checker.sv =====
`timescale 1ns / 100ps
// checker for the echo state network step: watches item, result and config channels,
// predicts each readout from its own copy of the state and compares in order
// depends on esn_pkg and esn_if

module esn_checker #(
  parameter int RES = 64,
  parameter int IN  = 8,
  parameter int OUT = 4
) (
  input  logic clk,
  input  logic rst,
  esn_in_if    items,
  esn_out_if   results,
  esn_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  import esn_pkg::*;

  typedef struct packed {
    logic [OIDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } readout_t;

  readout_t                expected_q[$];
  logic signed [VAL_W-1:0] w_in[RES*IN];
  logic signed [VAL_W-1:0] w_rec[RES*RES];
  logic signed [VAL_W-1:0] w_ro[OUT*RES];
  logic signed [VAL_W-1:0] neuron[RES];
  logic signed [VAL_W-1:0] prev[RES];
  logic signed [VAL_W-1:0] samples[IN];
  logic signed [VAL_W-1:0] tanh_lut[TANH_N];
  logic [LEAK_W-1:0]       leak;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // decaying exponential in Q0.30, tanh magnitude from it
  initial begin : lut_fill
    longint unsigned u, num, den, mag;
    int m;
    u = 64'd1 << 30;
    for (m = 0; m <= 512; m++) begin
      num = (64'd1 << 30) - u;
      den = (64'd1 << 30) + u;
      mag = (num * 8192 + den) / (2 * den);
      if (512 + m < TANH_N) tanh_lut[512 + m] = mag[VAL_W-1:0];
      if (m > 0) tanh_lut[512 - m] = -$signed(mag[VAL_W-1:0]);
      u = (u * 64'd1040706261 + (64'd1 << 29)) >> 30;
    end
  end

  function automatic logic signed [VAL_W-1:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] squash(longint s);
    longint span;
    span = longint'(8) << 24;
    if (s < -span) return tanh_lut[0];
    if (s >= span) return tanh_lut[TANH_N-1];
    return tanh_lut[(s + span) >>> 18];
  endfunction

  task automatic run_update();
    longint acc, a;
    int i, j;
    readout_t r;
    a = (leak > LEAK_ONE) ? 4096 : longint'(leak);
    prev = neuron;
    for (i = 0; i < RES; i++) begin
      acc = 0;
      for (j = 0; j < IN; j++) acc += longint'(w_in[i*IN + j]) * samples[j];
      for (j = 0; j < RES; j++) acc += longint'(w_rec[i*RES + j]) * prev[j];
      acc = (4096 - a) * prev[i] + a * squash(acc) + 2048;
      neuron[i] = clip16(acc >>> 12);
    end
    for (i = 0; i < OUT; i++) begin
      acc = 0;
      for (j = 0; j < RES; j++) acc += longint'(w_ro[i*RES + j]) * neuron[j];
      r.idx  = i[OIDX_W-1:0];
      r.val  = clip16((acc + 2048) >>> 12);
      r.last = (i == OUT - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic take_item();
    int r, c;
    r = items.row;
    c = items.col;
    case (items.command)
      CMD_IN_W:   if (r < RES && c < IN) w_in[r*IN + c] = items.value;
      CMD_REC_W:  if (r < RES && c < RES) w_rec[r*RES + c] = items.value;
      CMD_RO_W:   if (r < OUT && c < RES) w_ro[r*RES + c] = items.value;
      CMD_CLEAR: begin
        foreach (neuron[k]) neuron[k] = '0;
        foreach (prev[k]) prev[k] = '0;
      end
      CMD_SAMPLE: begin
        if (c < IN) samples[c] = items.value;
        if (items.last) run_update();
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    readout_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result index %0d value %0d last %0b",
                 results.out_index, results.out_value, results.out_last);
      return;
    end
    e = expected_q.pop_front();
    if (e.idx !== results.out_index || e.val !== results.out_value ||
        e.last !== results.out_last) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                 e.idx, e.val, e.last, results.out_index, results.out_value,
                 results.out_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (w_in[k]) w_in[k] = '0;
      foreach (w_rec[k]) w_rec[k] = '0;
      foreach (w_ro[k]) w_ro[k] = '0;
      foreach (neuron[k]) neuron[k] = '0;
      foreach (prev[k]) prev[k] = '0;
      foreach (samples[k]) samples[k] = '0;
      leak = LEAK_RESET;
      expected_q.delete();
    end else begin
      if (results.valid && results.ready) check_result();
      if (cfg.valid && cfg.ready) leak = cfg.leak_factor;
      if (items.valid && items.ready) take_item();
    end
    pending = expected_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the echo state network step: loads every weight, then
// directed and random items over several leak rates; esn_checker does the checking
// depends on esn_pkg, esn_if, esn_checker and the rtl top

module testbench;
  import esn_pkg::*;

  localparam int RES = 64;
  localparam int IN  = 8;
  localparam int OUT = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idle_enable = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_done = 1'b0;
  int   errors;
  int   pending;

  esn_in_if  items();
  esn_out_if results();
  esn_cfg_if cfg();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  echo_state_reservoir_step_top #(
    .NUM_NEURONS(RES), .NUM_INPUTS(IN), .NUM_OUTPUTS(OUT)
  ) u_top (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg)
  );

  esn_checker #(.RES(RES), .IN(IN), .OUT(OUT)) u_check (
    .clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin
    results.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done && results.valid) begin
        hold_done = 1'b1;
        results.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        results.ready <= !(idle_enable && $urandom_range(99) < 37);
      end
    end
  end

  task automatic send(int c, int r, int col, int v, int l);
    if (idle_enable)
      while ($urandom_range(99) < 37) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    items.valid   <= 1'b1;
    items.command <= CMD_W'(c);
    items.row     <= IDX_W'(r);
    items.col     <= IDX_W'(col);
    items.value   <= VAL_W'(v);
    items.last    <= l[0];
    do @(posedge clk); while (!items.ready);
  endtask

  task automatic write_leak(logic [LEAK_W-1:0] v);
    cfg.valid       <= 1'b1;
    cfg.leak_factor <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] any_value();
    if ($urandom_range(1)) return VAL_W'($urandom);
    return VAL_W'($urandom_range(1023) - 512);
  endfunction

  task automatic random_item();
    int k;
    int c;
    k = $urandom_range(99);
    if (k < 25) begin
      send(CMD_SAMPLE, $urandom, $urandom_range(IN-1), any_value(), 1'b1);
    end else if (k < 55) begin
      send(CMD_SAMPLE, $urandom, $urandom_range(IN-1), any_value(), 1'b0);
    end else if (k < 80) begin
      c = $urandom_range(int'(CMD_RO_W));
      send(c, (c == CMD_RO_W) ? $urandom_range(OUT-1) : $urandom,
           (c == CMD_IN_W) ? $urandom_range(IN-1) : $urandom, any_value(), $urandom);
    end else if (k < 88) begin
      send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (k < 92) begin
      send($urandom_range(7, CMD_SAMPLE + 1), $urandom, $urandom, $urandom, $urandom);
    end else if (k < 96) begin
      if ($urandom_range(1))
        send(CMD_IN_W, $urandom, $urandom_range(63, IN), $urandom, $urandom);
      else
        send(CMD_RO_W, $urandom_range(63, OUT), $urandom, $urandom, $urandom);
    end else begin
      send(CMD_SAMPLE, $urandom, $urandom_range(63, IN), $urandom, $urandom);
    end
  endtask

  initial begin
    logic [LEAK_W-1:0] leaks[4];
    int r, c, p, n;
    items.valid = 1'b0;
    items.command = '0;
    items.row = '0;
    items.col = '0;
    items.value = '0;
    items.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.leak_factor = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_leak(LEAK_RESET);

    // fill every weight store so no unwritten weight is ever read
    for (r = 0; r < RES; r++)
      for (c = 0; c < IN; c++) send(CMD_IN_W, r, c, $urandom, 1'b0);
    for (r = 0; r < RES; r++)
      for (c = 0; c < RES; c++) send(CMD_REC_W, r, c, any_value(), 1'b0);
    for (r = 0; r < OUT; r++)
      for (c = 0; c < RES; c++) send(CMD_RO_W, r, c, $urandom, 1'b0);

    idle_enable = 1'b1;
    send(CMD_SAMPLE, 0, 0, 16'h7FFF, 1'b0);
    send(CMD_SAMPLE, 63, IN - 1, 16'h8000, 1'b0);
    send(CMD_SAMPLE, 0, 63, 16'h1234, 1'b1);
    send(CMD_IN_W, 63, IN - 1, 16'h8000, 1'b1);
    send(CMD_IN_W, 0, 63, 16'h7FFF, 1'b0);
    send(CMD_REC_W, 63, 63, 16'h7FFF, 1'b0);
    send(CMD_RO_W, OUT - 1, 63, 16'h8000, 1'b0);
    send(CMD_RO_W, 63, 0, 16'h7FFF, 1'b0);
    for (c = CMD_SAMPLE + 1; c < 8; c++) send(c, 0, 0, 16'h7FFF, 1'b1);
    send(CMD_SAMPLE, 0, 1, 16'h0000, 1'b1);
    send(CMD_CLEAR, 0, 0, 16'h0000, 1'b1);
    send(CMD_SAMPLE, 0, 2, 16'hFFFF, 1'b1);
    drain();
    write_leak('0);
    send(CMD_SAMPLE, 0, 3, 16'h4000, 1'b1);
    drain();
    write_leak(LEAK_ONE);
    send(CMD_SAMPLE, 0, 4, 16'hC000, 1'b1);
    drain();
    write_leak('1);
    send(CMD_SAMPLE, 0, 5, 16'h0800, 1'b1);
    drain();

    leaks[0] = LEAK_W'($urandom_range(4096));
    leaks[1] = LEAK_ONE;
    leaks[2] = LEAK_W'($urandom);
    leaks[3] = LEAK_W'($urandom_range(400));
    for (p = 0; p < 4; p++) begin
      write_leak(leaks[p]);
      idle_enable = (p != 0);
      hold_request = (p != 0);
      for (n = 0; n < 25; n++) random_item();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/esn_pkg.sv
rtl/esn_if.sv
rtl/esn_ram.sv
rtl/echo_state_reservoir_step_top.sv
test/esn_checker.sv
test/testbench.sv
